[rtl/core/quoted_brace_arg_tokenizer_core_defines.svh]
// assertion macros for the quoted brace argument tokenizer checker
// depends on: a clk and an arst_n signal in the scope of each use
`ifndef QUOTED_BRACE_ARG_TOKENIZER_CORE_DEFINES_SVH
`define QUOTED_BRACE_ARG_TOKENIZER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define QBT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qbt check failed: same-cycle rule");

// next-cycle implication, disabled while in reset
`define QBT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qbt check failed: next-cycle rule");

`endif

[rtl/core/qbt_pkg.sv]
// shared types and constants for the quoted brace argument tokenizer
// depends on: nothing
package qbt_pkg;

	localparam int LINE_BYTES = 1024;
	localparam int MAX_ARGS   = 32;

	// internal state widths hold the limits themselves
	localparam int FILL_W = $clog2(LINE_BYTES + 1);
	localparam int ARGS_W = $clog2(MAX_ARGS + 1);

	// fixed result field widths
	localparam int OFFSET_W = 10;
	localparam int INDEX_W  = 5;
	localparam int COUNT_W  = 6;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_WORD  = 3'd1,
		MODE_QUOTE = 3'd2,
		MODE_BRACE = 3'd3,
		MODE_DRAIN = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CHK_NONE  = 2'd0,
		CHK_BRACE = 2'd1,
		CHK_QUOTE = 2'd2
	} chk_t;

	typedef enum logic [2:0] {
		ST_BUSY        = 3'd0,
		ST_DONE        = 3'd1,
		ST_OPEN_BRACE  = 3'd2,
		ST_OPEN_QUOTE  = 3'd3,
		ST_BAD_BRACE   = 3'd4,
		ST_BAD_QUOTE   = 3'd5,
		ST_FULL        = 3'd6,
		ST_IGNORED     = 3'd7
	} status_t;

	typedef struct packed {
		mode_t              mode;
		chk_t               chk;
		logic [FILL_W-1:0]  fill;
		logic [ARGS_W-1:0]  args;
	} lex_state_t;

	typedef struct packed {
		logic                 write_en;
		logic [7:0]           write_byte;
		logic [OFFSET_W-1:0]  write_offset;
		logic                 arg_start;
		logic [INDEX_W-1:0]   arg_index;
		logic [COUNT_W-1:0]   arg_count;
		status_t              status;
	} lex_result_t;

	localparam lex_state_t LEX_CLEAR = '{
		mode: MODE_IDLE, chk: CHK_NONE, fill: '0, args: '0
	};

endpackage

[rtl/core/quoted_brace_arg_tokenizer_core.sv]
// an input transaction passes the input register and then the result register before its result is offered
// throughput: one character per cycle while out_ready does not stall the result stage; the lexer state loop closes
// through qbt_step between the input register and the result register
// reset: arst_n clears the lexer state to idle with an empty buffer and both stages empty
// top level of the quoted brace argument tokenizer; depends on qbt_pkg and qbt_step
module quoted_brace_arg_tokenizer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       write_en,
	output logic [7:0] write_byte,
	output logic [qbt_pkg::OFFSET_W-1:0] write_offset,
	output logic       arg_start,
	output logic [qbt_pkg::INDEX_W-1:0]  arg_index,
	output logic [qbt_pkg::COUNT_W-1:0]  arg_count,
	output logic [2:0] status
);
	import qbt_pkg::*;

	logic        v_s1;
	logic [7:0]  ch_s1;
	logic        v_s2;
	lex_result_t res_s2;
	lex_state_t  state_q;
	lex_state_t  state_nxt;
	lex_result_t res_nxt;
	logic        advance;

	// stage 2 frees when empty or when its result is taken
	assign advance  = !v_s2 || out_ready;
	assign in_ready = !v_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1 <= ch;
		end
	end

	qbt_step u_step (
		.ch  (ch_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// lexer state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			state_q <= LEX_CLEAR;
		end else if (advance) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid    = v_s2;
	assign write_en     = res_s2.write_en;
	assign write_byte   = res_s2.write_byte;
	assign write_offset = res_s2.write_offset;
	assign arg_start    = res_s2.arg_start;
	assign arg_index    = res_s2.arg_index;
	assign arg_count    = res_s2.arg_count;
	assign status       = res_s2.status;

endmodule

[rtl/core/qbt_step.sv]
// next-state and result logic for one character of the tokenizer
// depends on: qbt_pkg
module qbt_step (
	input  logic [7:0]          ch,
	input  qbt_pkg::lex_state_t cur,
	output qbt_pkg::lex_state_t nxt,
	output qbt_pkg::lex_result_t res
);
	import qbt_pkg::*;

	logic       is_nul;
	logic       is_space;
	logic       chk_fail;
	logic       full;
	logic       end_line;
	logic       drain;
	logic [7:0] closer;
	logic [ARGS_W-1:0] args_new;

	// character classes and the deferred closer check
	assign is_nul   = (ch == CH_NUL);
	assign is_space = (ch == CH_SPACE);
	assign chk_fail = (cur.chk != CHK_NONE) && !is_nul && !is_space
		&& !((cur.chk == CHK_BRACE) && (ch == CH_RPAREN));
	assign full     = (cur.fill >= FILL_W'(LINE_BYTES));
	assign closer   = (cur.mode == MODE_BRACE) ? CH_RBRACE : CH_DQUOTE;
	assign args_new = cur.args + ARGS_W'(1);

	// mode update and buffer writes
	always_comb begin
		nxt      = cur;
		res      = '0;
		res.status = ST_BUSY;
		end_line = 1'b0;
		drain    = 1'b0;
		if (cur.mode == MODE_DRAIN) begin
			res.arg_count = COUNT_W'(cur.args);
			res.status    = ST_IGNORED;
			if (is_nul) begin
				nxt = LEX_CLEAR;
			end
		end else if (chk_fail) begin
			res.arg_count = COUNT_W'(cur.args);
			res.status    = (cur.chk == CHK_BRACE) ? ST_BAD_BRACE : ST_BAD_QUOTE;
			nxt.mode      = MODE_DRAIN;
			nxt.chk       = CHK_NONE;
		end else begin
			nxt.chk = CHK_NONE;
			if (full) begin
				res.status = ST_FULL;
				if (is_nul) begin
					end_line = 1'b1;
				end else begin
					drain = 1'b1;
				end
			end else if (cur.mode == MODE_BRACE || cur.mode == MODE_QUOTE) begin
				if (is_nul) begin
					res.status = (cur.mode == MODE_BRACE) ? ST_OPEN_BRACE : ST_OPEN_QUOTE;
					end_line   = 1'b1;
				end else begin
					res.write_en     = 1'b1;
					res.write_offset = cur.fill[OFFSET_W-1:0];
					nxt.fill         = cur.fill + FILL_W'(1);
					if (ch == closer) begin
						res.write_byte = CH_NUL;
						nxt.mode       = MODE_IDLE;
						nxt.chk        = (cur.mode == MODE_BRACE) ? CHK_BRACE : CHK_QUOTE;
					end else begin
						res.write_byte = ch;
					end
				end
			end else if (cur.mode == MODE_WORD) begin
				res.write_en     = 1'b1;
				res.write_offset = cur.fill[OFFSET_W-1:0];
				nxt.fill         = cur.fill + FILL_W'(1);
				if (is_nul || is_space) begin
					res.write_byte = CH_NUL;
					nxt.mode       = MODE_IDLE;
					if (is_nul) begin
						res.status = ST_DONE;
						end_line   = 1'b1;
					end
				end else begin
					res.write_byte = ch;
				end
			end else begin
				// idle between arguments
				if (is_nul) begin
					res.status = ST_DONE;
					end_line   = 1'b1;
				end else if (!is_space) begin
					res.write_offset = cur.fill[OFFSET_W-1:0];
					res.arg_start    = 1'b1;
					res.arg_index    = cur.args[INDEX_W-1:0];
					nxt.args         = args_new;
					if (ch == CH_LBRACE) begin
						nxt.mode = MODE_BRACE;
					end else if (ch == CH_DQUOTE) begin
						nxt.mode = MODE_QUOTE;
					end else begin
						res.write_en   = 1'b1;
						res.write_byte = ch;
						nxt.fill       = cur.fill + FILL_W'(1);
						nxt.mode       = MODE_WORD;
					end
					if (args_new >= ARGS_W'(MAX_ARGS)) begin
						res.status = ST_DONE;
						drain      = 1'b1;
					end
				end
			end
			res.arg_count = COUNT_W'(nxt.args);
			if (end_line) begin
				nxt = LEX_CLEAR;
			end else if (drain) begin
				nxt.mode = MODE_DRAIN;
				nxt.chk  = CHK_NONE;
			end
		end
	end

endmodule

[rtl/core/qbt_checker.sv]
// port-level checks for the quoted brace argument tokenizer, bound to the top level
// depends on: qbt_pkg, quoted_brace_arg_tokenizer_core_defines.svh
`include "quoted_brace_arg_tokenizer_core_defines.svh"

module qbt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       write_en,
	input logic [7:0] write_byte,
	input logic [qbt_pkg::OFFSET_W-1:0] write_offset,
	input logic       arg_start,
	input logic [qbt_pkg::INDEX_W-1:0]  arg_index,
	input logic [qbt_pkg::COUNT_W-1:0]  arg_count,
	input logic [2:0] status
);
	import qbt_pkg::*;

	// no byte written means a zero byte field
	`QBT_ASSERT_NOW(a_idle_byte, out_valid && !write_en, write_byte == 8'h00)

	// an argument opens only while parsing, never on an error
	`QBT_ASSERT_NOW(a_start_status, out_valid && arg_start,
		status == ST_BUSY || status == ST_DONE)

	// the count includes the argument just opened
	`QBT_ASSERT_NOW(a_start_count, out_valid && arg_start,
		arg_count == ({1'b0, arg_index} + 6'd1))

	// a stalled result transaction holds
	`QBT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(write_offset) && $stable(status) && $stable(arg_count))

endmodule

bind quoted_brace_arg_tokenizer_core qbt_checker u_qbt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.write_en     (write_en),
	.write_byte   (write_byte),
	.write_offset (write_offset),
	.arg_start    (arg_start),
	.arg_index    (arg_index),
	.arg_count    (arg_count),
	.status       (status)
);
